>>> sv/sktl_pkg.sv
// Shared types, codes and widths for the sorted key table lookup block.
package sktl_pkg;

   localparam int DEFAULT_DEPTH = 256;

   localparam int KEY_W      = 32;
   localparam int OFFSET_W   = 32;
   localparam int SLOT_W     = 8;
   localparam int CSR_W      = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int REQ_DATA_W = 72;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 2;

   localparam int QDEPTH = 2;
   localparam int QAW    = $clog2(QDEPTH);

   localparam logic [CSR_ADDR_W-1:0] CSR_REGION      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INDEX_TABLE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_VALUE_TABLE = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEAP_START  = 2'd3;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [RSP_USER_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [RSP_USER_W-1:0] STATUS_NOT_FOUND  = 2'd1;
   localparam logic [RSP_USER_W-1:0] STATUS_BAD_OFFSET = 2'd2;
   localparam logic [RSP_USER_W-1:0] STATUS_BAD_HEADER = 2'd3;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_SKIP,
      KIND_BAD_HEADER,
      KIND_SEARCH
   } kind_type;

   typedef enum logic {
      S_IDLE,
      S_SEARCH
   } state_type;

   typedef struct packed {
      kind_type              kind;
      logic [SLOT_W-1:0]     slot;
      logic [KEY_W-1:0]      key;
      logic [OFFSET_W-1:0]   eoff;
   } entry_type;

endpackage

>>> sv/sktl_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
module sktl_front #(
   parameter int DEPTH = sktl_pkg::DEFAULT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sktl_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [sktl_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic [sktl_pkg::CSR_W-1:0]          region_bytes,
   input  logic [sktl_pkg::CSR_W-1:0]          index_table_bytes,
   input  logic [sktl_pkg::CSR_W-1:0]          value_table_bytes,
   input  logic [sktl_pkg::CSR_W-1:0]          heap_start_bytes,
   output logic                                q_valid,
   input  logic                                q_pop,
   output sktl_pkg::entry_type                 q_entry
);

   sktl_pkg::entry_type              entry_ff [sktl_pkg::QDEPTH];
   sktl_pkg::entry_type              new_entry;
   logic [sktl_pkg::QAW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [sktl_pkg::QAW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [sktl_pkg::QAW:0]           count_ff, count_in;
   logic                             push;
   logic                             hdr_ok;
   logic                             slot_ok;

   // header sanity; the user must keep config stable while requests are in flight, the block does not enforce it
   assign hdr_ok = (index_table_bytes <= region_bytes) &&
                   (index_table_bytes[1:0] == 2'b00) &&
                   (value_table_bytes <= region_bytes) &&
                   (value_table_bytes[1:0] == 2'b00) &&
                   (value_table_bytes >= index_table_bytes) &&
                   (heap_start_bytes <= region_bytes) &&
                   ((index_table_bytes >> 2) <= 32'(DEPTH));

   assign slot_ok = {24'd0, req_tdata[7:0]} < 32'(DEPTH);

   always_comb begin
      new_entry.slot = req_tdata[7:0];
      new_entry.key  = req_tdata[39:8];
      new_entry.eoff = req_tdata[71:40];
      if (req_tuser[0] == sktl_pkg::CMD_WRITE) begin
         new_entry.kind = slot_ok ? sktl_pkg::KIND_WRITE : sktl_pkg::KIND_SKIP;
      end else begin
         new_entry.kind = hdr_ok ? sktl_pkg::KIND_SEARCH : sktl_pkg::KIND_BAD_HEADER;
      end
   end

   assign req_tready = (count_ff != (sktl_pkg::QAW+1)'(sktl_pkg::QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_entry    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? sktl_pkg::QAW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? sktl_pkg::QAW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

>>> sv/sktl_back.sv
// Back end: key/offset tables, binary search engine and response register.
module sktl_back #(
   parameter int DEPTH = sktl_pkg::DEFAULT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   output logic                                q_pop,
   input  sktl_pkg::entry_type                 q_entry,
   input  logic [sktl_pkg::CSR_W-1:0]          index_table_bytes,
   input  logic [sktl_pkg::CSR_W-1:0]          heap_start_bytes,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sktl_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [sktl_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;
   localparam int SW = CW + 1;

   logic [sktl_pkg::KEY_W-1:0]       key_mem [DEPTH];
   logic [sktl_pkg::OFFSET_W-1:0]    off_mem [DEPTH];
   logic [sktl_pkg::KEY_W-1:0]       key_rd_ff;
   logic [sktl_pkg::OFFSET_W-1:0]    off_rd_ff;

   sktl_pkg::state_type              state_ff, state_in;
   logic [CW-1:0]                    lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]                    mid_ff, mid_in;
   logic [sktl_pkg::KEY_W-1:0]       key_ff, key_in;
   logic [CW-1:0]                    n, nlo, nhi;
   logic [SW-1:0]                    sum;
   logic [AW-1:0]                    wr_addr;
   logic                             mem_we;
   logic                             load;
   logic                             out_free;
   logic [sktl_pkg::RSP_USER_W-1:0]  res_status;
   logic [sktl_pkg::SLOT_W-1:0]      res_slot;
   logic [sktl_pkg::OFFSET_W-1:0]    res_off;
   logic [sktl_pkg::OFFSET_W-1:0]    res_len;

   logic                             rsp_valid_ff;
   logic [sktl_pkg::RSP_USER_W-1:0]  rsp_status_ff;
   logic [sktl_pkg::SLOT_W-1:0]      rsp_slot_ff;
   logic [sktl_pkg::OFFSET_W-1:0]    rsp_off_ff;
   logic [sktl_pkg::OFFSET_W-1:0]    rsp_len_ff;

   // header check bounds this count to DEPTH for searched requests
   assign n        = index_table_bytes[CW+1:2];
   assign wr_addr  = AW'(q_entry.slot);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      key_in     = key_ff;
      q_pop      = 1'b0;
      mem_we     = 1'b0;
      load       = 1'b0;
      res_status = sktl_pkg::STATUS_OK;
      res_slot   = '0;
      res_off    = '0;
      res_len    = '0;
      nlo        = lo_ff;
      nhi        = hi_ff;
      sum        = '0;
      case (state_ff)
         sktl_pkg::S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop  = 1'b1;
               key_in = q_entry.key;
               case (q_entry.kind)
                  sktl_pkg::KIND_WRITE: begin
                     mem_we = 1'b1;
                     load   = 1'b1;
                  end
                  sktl_pkg::KIND_BAD_HEADER: begin
                     load       = 1'b1;
                     res_status = sktl_pkg::STATUS_BAD_HEADER;
                  end
                  sktl_pkg::KIND_SEARCH: begin
                     if (n == '0) begin
                        load       = 1'b1;
                        res_status = sktl_pkg::STATUS_NOT_FOUND;
                     end else begin
                        lo_in    = '0;
                        hi_in    = n;
                        sum      = SW'(n) - SW'(1);
                        mid_in   = AW'(sum >> 1);
                        state_in = sktl_pkg::S_SEARCH;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         sktl_pkg::S_SEARCH: begin
            if (key_ff == key_rd_ff) begin
               load     = 1'b1;
               res_slot = sktl_pkg::SLOT_W'(mid_ff);
               res_off  = off_rd_ff;
               if (off_rd_ff >= heap_start_bytes) begin
                  res_status = sktl_pkg::STATUS_BAD_OFFSET;
               end else begin
                  res_len = heap_start_bytes - off_rd_ff;
               end
               state_in = sktl_pkg::S_IDLE;
            end else begin
               if (key_ff < key_rd_ff) begin
                  nhi = CW'(mid_ff);
               end else begin
                  nlo = CW'(mid_ff) + CW'(1);
               end
               lo_in = nlo;
               hi_in = nhi;
               if (nlo < nhi) begin
                  sum    = SW'(nlo) + SW'(nhi) - SW'(1);
                  mid_in = AW'(sum >> 1);
               end else begin
                  load       = 1'b1;
                  res_status = sktl_pkg::STATUS_NOT_FOUND;
                  state_in   = sktl_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = sktl_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sktl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      key_ff <= key_in;
   end

   // tables: one write port, one registered read port at the next probe
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[wr_addr] <= q_entry.key;
         off_mem[wr_addr] <= q_entry.eoff;
      end
   end

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[mid_in];
      off_rd_ff <= off_mem[mid_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
         rsp_off_ff    <= res_off;
         rsp_len_ff    <= res_len;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_off_ff, rsp_slot_ff};

   a_search_out_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sktl_pkg::S_SEARCH) |-> !rsp_valid_ff)
      else $error("response register busy during search");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sktl_pkg::S_SEARCH) |->
         (lo_ff <= CW'(mid_ff) && CW'(mid_ff) < hi_ff))
      else $error("probe outside search window");

   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> out_free)
      else $error("queue popped while response register blocked");

   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_entry.kind != sktl_pkg::KIND_SEARCH) |=> rsp_valid_ff)
      else $error("non-search request produced no response");

endmodule

>>> sv/sorted_key_table_lookup.sv
// Top level of the sorted key table lookup block: config registers and front/back ends.
//
// Usage:
//   req_* carries requests: tuser[0] is cmd (0 write a slot, 1 look up a key).
//   A write stores key and entry_offset at slot; a lookup binary-searches the
//   first index_table_bytes/4 slots (sorted ascending) for key.
//   rsp_* returns exactly one response per request, in request order:
//   tuser is the status (ok, not_found, bad_offset, bad_header).
//   csr_* writes the four header registers; write only while the block is idle.
// Flow:
//   A write or a rejected lookup passes through the queue and then the
//   response register. A lookup searches in the back end, one table read
//   per probe, paced by the single table read port and the compare that
//   picks the next probe; no new request is taken until the search ends.
//   A two-entry queue sits between the front and back ends.
// Reset clears the config registers, queue and search engine; table contents
// are undefined until written. When rsp_tready is low the response is held,
// the back end waits and the queue keeps accepting up to two requests.
module sorted_key_table_lookup #(
   parameter int DEPTH = sktl_pkg::DEFAULT_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sktl_pkg::REQ_DATA_W-1:0]     req_tdata,   // [7:0] slot, [39:8] key,
                                                            // [71:40] entry_offset
   input  logic [sktl_pkg::REQ_USER_W-1:0]     req_tuser,   // [0] cmd
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sktl_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // [7:0] found_slot,
                                                            // [39:8] value_offset,
                                                            // [71:40] data_length
   output logic [sktl_pkg::RSP_USER_W-1:0]     rsp_tuser,   // [1:0] status
   input  logic                                csr_we,
   input  logic [sktl_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sktl_pkg::CSR_W-1:0]          csr_wdata
);

   logic [sktl_pkg::CSR_W-1:0]  region_ff;
   logic [sktl_pkg::CSR_W-1:0]  index_table_ff;
   logic [sktl_pkg::CSR_W-1:0]  value_table_ff;
   logic [sktl_pkg::CSR_W-1:0]  heap_start_ff;

   logic                        q_valid;
   logic                        q_pop;
   sktl_pkg::entry_type         q_entry;

   // header registers
   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff      <= '0;
         index_table_ff <= '0;
         value_table_ff <= '0;
         heap_start_ff  <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            sktl_pkg::CSR_REGION:      region_ff      <= csr_wdata;
            sktl_pkg::CSR_INDEX_TABLE: index_table_ff <= csr_wdata;
            sktl_pkg::CSR_VALUE_TABLE: value_table_ff <= csr_wdata;
            sktl_pkg::CSR_HEAP_START:  heap_start_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front end classifies: write, out-of-range write, bad header, search
   sktl_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .region_bytes      (region_ff),
      .index_table_bytes (index_table_ff),
      .value_table_bytes (value_table_ff),
      .heap_start_bytes  (heap_start_ff),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_entry           (q_entry)
   );

   // back end owns the tables and runs the search
   sktl_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_entry           (q_entry),
      .index_table_bytes (index_table_ff),
      .heap_start_bytes  (heap_start_ff),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser)
   );

endmodule
